>>> sv/swtm_pkg.sv
package swtm_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_OLD,
		ST_RM_SCAN,
		ST_RM_SHIFT,
		ST_INS_SHIFT,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} swtm_state_t;

	localparam logic [0:0] CFG_WINDOW_LEN = 1'b0;
	localparam logic [0:0] CFG_TRIM_COUNT = 1'b1;
	localparam int CFG_INDEX_BITS = 1;
	localparam int WINDOW_LEN_BITS = 7;
	localparam int TRIM_BITS = 5;
	localparam int OUT_BITS = 16;
	localparam logic [WINDOW_LEN_BITS-1:0] WINDOW_LEN_RESET = 7'd64;
	localparam logic [TRIM_BITS-1:0] TRIM_RESET = 5'd1;

	// Divider handshake between the sequencer and the divide unit.
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} swtm_div_ctl_t;

endpackage

>>> sv/swtm_div.sv
module swtm_div
	import swtm_pkg::*;
#(
	parameter int NUM_BITS = 22,
	parameter int DEN_BITS = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output swtm_div_ctl_t       ctl,
	output logic [NUM_BITS-1:0] quo
);

	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS:0]   rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [DEN_BITS:0]   rem_sh;
	logic                ge;

	// One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
	assign rem_sh = {rem_q[DEN_BITS-1:0], quo_q[NUM_BITS-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[NUM_BITS-2:0], ge};
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign quo       = quo_q;

endmodule

>>> sv/sliding_window_trimmed_mean.sv
// Sliding-window alpha-trimmed mean. Each accepted sample word enters a window of the
// last window_len samples (clamped to 1..WINDOW_MAX), held both in arrival order in a
// history memory and in ascending order in a sorted memory. One result word follows each
// sample: valid_res is 1 once the window is full and 2*trim_count < the clamped length,
// and then trimmed_mean is the floor mean of the sorted window with trim_count values
// dropped at each end; otherwise both are 0. The block handles one sample at a time and
// is not ready while it works. The sorted memory has one port, so each sample is worked
// in steps: if the window is full, find the oldest value and shift its successors down;
// then shift in the new one, sum the middle band, run the bit-serial divider and raise
// the result. A write to either register empties the window, so it must refill before a
// valid result. Neither memory needs clearing after reset; unwritten entries go unused.
module sliding_window_trimmed_mean
	import swtm_pkg::*;
#(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [15:0]                sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       valid_res,
	output logic [OUT_BITS-1:0]        trimmed_mean,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [WINDOW_LEN_BITS-1:0] cfg_data
);

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int LW = $clog2(WINDOW_MAX + 1);
	localparam int SW = SAMPLE_BITS + LW;
	localparam int CW = (LW > WINDOW_LEN_BITS) ? LW : WINDOW_LEN_BITS;

	logic [SAMPLE_BITS-1:0] hist_mem [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] sort_mem [WINDOW_MAX];

	swtm_state_t state_q, state_d;

	logic [WINDOW_LEN_BITS-1:0] window_len_q;
	logic [TRIM_BITS-1:0]       trim_q;
	logic [LW-1:0]              fill_q;
	logic [AW-1:0]              oldest_q;
	logic [LW-1:0]              idx_q;
	logic [SAMPLE_BITS-1:0]     new_q;
	logic [SAMPLE_BITS-1:0]     old_q;
	logic [SW-1:0]              sum_q;
	logic                       res_valid_q;
	logic [OUT_BITS-1:0]        res_mean_q;
	logic                       out_valid_q;
	logic                       full_q;
	logic [SAMPLE_BITS-1:0]     srd_q;
	logic                       srd_ok_q;

	logic [LW-1:0]          eff_len;
	logic                   legal;
	logic [LW:0]            band;
	logic [LW-1:0]          ins_count;
	logic [AW-1:0]          wr_slot;
	logic                   div_start;
	swtm_div_ctl_t          div_ctl;
	logic [SW-1:0]          div_quo;
	logic                   cfg_fire;
	logic                   in_fire;
	logic [CW-1:0]          len_ext;

	// Effective window length, clamped to 1..WINDOW_MAX.
	assign len_ext = CW'(window_len_q);
	always_comb begin
		if (window_len_q == '0) begin
			eff_len = LW'(1);
		end else if (len_ext > CW'(WINDOW_MAX)) begin
			eff_len = LW'(WINDOW_MAX);
		end else begin
			eff_len = LW'(window_len_q);
		end
	end

	assign band  = {1'b0, eff_len} - (LW+1)'({trim_q, 1'b0});
	assign legal = ({trim_q, 1'b0} < (TRIM_BITS+1+LW)'(eff_len)) && !band[LW];

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// Entries in the sorted memory before the new sample goes in.
	assign ins_count = full_q ? (eff_len - 1'b1) : fill_q;

	always_comb begin
		logic [LW:0] w;
		w = {1'b0, LW'(oldest_q)} + {1'b0, fill_q};
		if (w >= (LW+1)'(eff_len)) w = w - (LW+1)'(eff_len);
		wr_slot = full_q ? oldest_q : AW'(w);
	end

	// Sorted memory is read at one address per cycle. The scan and sum states fetch one
	// entry ahead once data is flowing; the insert reads idx_q-1 and the removal reads idx_q+1,
	// and both advance idx_q only when srd_ok_q marks the read data valid.
	logic [AW-1:0] srd_addr;
	always_comb begin
		case (state_q)
			ST_RM_SCAN,
			ST_SUM:       srd_addr = srd_ok_q ? AW'(idx_q + 1'b1) : AW'(idx_q);
			ST_RM_SHIFT:  srd_addr = AW'(idx_q + 1'b1);
			ST_INS_SHIFT: srd_addr = AW'(idx_q - 1'b1);
			default:      srd_addr = AW'(idx_q);
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = full_q ? ST_RD_OLD : ST_INS_SHIFT;
			end
			ST_RD_OLD:   state_d = ST_RM_SCAN;
			ST_RM_SCAN: begin
				if (srd_ok_q && srd_q == old_q) begin
					state_d = ST_RM_SHIFT;
				end else if (srd_ok_q && idx_q == eff_len - 1'b1) begin
					state_d = ST_INS_SHIFT;
				end
			end
			ST_RM_SHIFT: begin
				if (srd_ok_q && (idx_q + 1'b1) >= (eff_len - 1'b1)) state_d = ST_INS_SHIFT;
			end
			ST_INS_SHIFT: begin
				if (idx_q == '0 || (srd_ok_q && srd_q <= new_q)) state_d = ST_SUM;
			end
			ST_SUM: begin
				if (srd_ok_q && idx_q == fill_q - 1'b1) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_ctl.done) state_d = ST_OUT;
			end
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// The divider starts on the first divide cycle, once the last band entry is summed.
	always_comb begin
		div_start = (state_q == ST_DIV) && !div_ctl.busy && !div_ctl.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			window_len_q <= WINDOW_LEN_RESET;
			trim_q       <= TRIM_RESET;
			fill_q       <= '0;
			oldest_q     <= '0;
			full_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			srd_ok_q     <= 1'b0;
			idx_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cfg_fire) begin
				case (cfg_index)
					CFG_WINDOW_LEN: window_len_q <= cfg_data;
					CFG_TRIM_COUNT: trim_q <= cfg_data[TRIM_BITS-1:0];
					default: ;
				endcase
				fill_q   <= '0;
				oldest_q <= '0;
				full_q   <= 1'b0;
			end
			srd_ok_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (full_q) begin
							idx_q <= '0;
						end else begin
							idx_q    <= fill_q;
							srd_ok_q <= 1'b0;
						end
					end
				end
				ST_RD_OLD: srd_ok_q <= 1'b1;
				ST_RM_SCAN: begin
					if (srd_ok_q) begin
						if (srd_q == old_q) begin
							// Found it; shift successors down starting here.
						end else if (idx_q == eff_len - 1'b1) begin
							idx_q <= ins_count;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					srd_ok_q <= !(srd_ok_q && srd_q != old_q && idx_q == eff_len - 1'b1);
					if (srd_ok_q && srd_q == old_q) begin
						srd_ok_q <= 1'b0;
					end
				end
				ST_RM_SHIFT: begin
					srd_ok_q <= !srd_ok_q;
					if (srd_ok_q) begin
						if ((idx_q + 1'b1) >= (eff_len - 1'b1)) begin
							idx_q    <= ins_count;
							srd_ok_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_INS_SHIFT: begin
					srd_ok_q <= !srd_ok_q;
					if (idx_q == '0 || (srd_ok_q && srd_q <= new_q)) begin
						idx_q    <= '0;
						srd_ok_q <= 1'b0;
						if (!full_q) fill_q <= fill_q + 1'b1;
						if (full_q || fill_q + 1'b1 >= eff_len) full_q <= 1'b1;
						if (full_q) begin
							oldest_q <= (LW'(oldest_q) + 1'b1 >= eff_len) ? '0
								: AW'(oldest_q + 1'b1);
						end
					end else if (srd_ok_q) begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_SUM: begin
					srd_ok_q <= 1'b1;
					if (srd_ok_q) idx_q <= idx_q + 1'b1;
				end
				ST_OUT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// The RM_SCAN transition into RM_SHIFT when the hit is at the last slot skips
	// the shift: handled by RM_SHIFT's exit test on its first data cycle.

	logic in_band;
	assign in_band = (LW'(idx_q) >= LW'(trim_q)) && ((LW+1)'(idx_q) < (LW+1)'(eff_len)
		- (LW+1)'(trim_q));

	always_ff @(posedge clk) begin
		srd_q <= sort_mem[srd_addr];
		if (in_fire) begin
			new_q <= SAMPLE_BITS'(sample);
			hist_mem[wr_slot] <= SAMPLE_BITS'(sample);
			old_q <= hist_mem[wr_slot];
			sum_q <= '0;
		end
		case (state_q)
			ST_RM_SHIFT: begin
				if (srd_ok_q && (idx_q + 1'b1) < eff_len) sort_mem[AW'(idx_q)] <= srd_q;
			end
			ST_INS_SHIFT: begin
				if (idx_q == '0 || (srd_ok_q && srd_q <= new_q)) begin
					sort_mem[AW'(idx_q)] <= new_q;
				end else if (srd_ok_q) begin
					sort_mem[AW'(idx_q)] <= srd_q;
				end
			end
			ST_SUM: begin
				if (srd_ok_q && legal && in_band) sum_q <= sum_q + SW'(srd_q);
			end
			ST_DIV: begin
				if (div_ctl.done) begin
					res_valid_q <= full_q && legal;
					res_mean_q  <= (full_q && legal) ? OUT_BITS'(div_quo) : '0;
				end
			end
			default: ;
		endcase
	end

	swtm_div #(
		.NUM_BITS(SW),
		.DEN_BITS(LW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (sum_q),
		.den   (legal ? band[LW-1:0] : LW'(1)),
		.ctl   (div_ctl),
		.quo   (div_quo)
	);

	assign out_valid    = out_valid_q;
	assign valid_res    = res_valid_q;
	assign trimmed_mean = res_mean_q;

	// A result word is only raised by the final sequencer state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");

	// The divider never runs while the block would take a new sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.busy |-> !in_ready)
		else $error("divider busy while ready");

	// The fill count never passes WINDOW_MAX.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LW'(WINDOW_MAX))
		else $error("fill count overflow");

endmodule
